// ===== rtl/cke_pkg.sv =====
`default_nettype none

package cke_pkg;

    localparam int SYM_BITS   = 5;
    localparam int COUNT_W    = 48;
    localparam int CFG_DATA_W = 26;
    localparam int CFG_IDX_W  = 3;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_KMER_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_MASK  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FOLD_LOWER  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PUR_PYR     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CANONICAL   = 3'd4;

    localparam logic [3:0]            RST_KMER_LENGTH = 4'd10;
    localparam logic [CFG_DATA_W-1:0] RST_ALPHA_MASK  = 26'd532549;

    localparam logic [7:0] CH_GT    = 8'h3E;  // '>'
    localparam logic [7:0] CH_NL    = 8'h0A;  // '\n'
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    // letter codes (letter - 'A')
    localparam logic [SYM_BITS-1:0] SYM_A = 5'd0;
    localparam logic [SYM_BITS-1:0] SYM_C = 5'd2;
    localparam logic [SYM_BITS-1:0] SYM_G = 5'd6;
    localparam logic [SYM_BITS-1:0] SYM_R = 5'd17;
    localparam logic [SYM_BITS-1:0] SYM_T = 5'd19;
    localparam logic [SYM_BITS-1:0] SYM_Y = 5'd24;

    typedef struct packed {
        logic                restart;
        logic                clear;
        logic                append;
        logic [SYM_BITS-1:0] code;
    } t_op;

    function automatic logic [SYM_BITS-1:0] sym_complement(input logic [SYM_BITS-1:0] c);
        logic [SYM_BITS-1:0] r;
        case (c)
            SYM_A:   r = SYM_T;
            SYM_T:   r = SYM_A;
            SYM_C:   r = SYM_G;
            SYM_G:   r = SYM_C;
            SYM_R:   r = SYM_Y;
            SYM_Y:   r = SYM_R;
            default: r = c;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cke_front.sv =====
`default_nettype none

module cke_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    input  wire logic                           i_q_ready,
    input  wire logic [7:0]                     i_text_byte,
    input  wire logic                           i_restart,
    input  wire logic [cke_pkg::CFG_DATA_W-1:0] i_alpha_mask,
    input  wire logic                           i_fold_lower,
    input  wire logic                           i_pur_pyr,
    output      logic                           o_push,
    output      cke_pkg::t_op                   o_op
);
    import cke_pkg::*;

    logic r_in_header;
    logic n_in_header;
    logic accept;
    t_op  op;

    assign accept = i_in_valid && i_q_ready;

    always_comb begin
        logic [7:0]          b;
        logic [SYM_BITS-1:0] idx;
        logic                hdr;
        b           = i_text_byte;
        idx         = '0;
        hdr         = i_restart ? 1'b0 : r_in_header;
        n_in_header = hdr;
        op.restart  = i_restart;
        op.clear    = 1'b0;
        op.append   = 1'b0;
        op.code     = '0;
        if (b == CH_GT) begin
            n_in_header = 1'b1;
            op.clear    = 1'b1;
        end else if (hdr) begin
            if (b == CH_NL) begin
                n_in_header = 1'b0;
            end
        end else if (b != CH_NL) begin
            if (i_fold_lower && b >= CH_LO_A && b <= CH_LO_Z) begin
                b = b - CASE_OFS;
            end
            idx = SYM_BITS'(b - CH_UP_A);
            if (b < CH_UP_A || b > CH_UP_Z || !i_alpha_mask[idx]) begin
                op.clear = 1'b1;
            end else begin
                op.append = 1'b1;
                op.code   = idx;
                if (i_pur_pyr) begin
                    if (idx == SYM_A || idx == SYM_G) begin
                        op.code = SYM_R;
                    end else if (idx == SYM_C || idx == SYM_T) begin
                        op.code = SYM_Y;
                    end
                end
            end
        end
    end

    // header bytes other than '>' and stray newlines carry no work unless they restart
    assign o_push = accept && (op.restart || op.clear || op.append);
    assign o_op   = op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_header <= 1'b0;
        end else if (accept) begin
            r_in_header <= n_in_header;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cke_fifo.sv =====
`default_nettype none

module cke_fifo (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire cke_pkg::t_op i_op,
    input  wire logic         i_pop,
    output      logic         o_ready,
    output      logic         o_valid,
    output      cke_pkg::t_op o_op
);
    import cke_pkg::*;

    t_op        r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       do_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_op    = r_mem[r_rp];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, do_pop};
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && !o_ready))
        else $error("push into full queue");

    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("queue count out of range");

endmodule

`default_nettype wire

// ===== rtl/cke_back.sv =====
`default_nettype none

module cke_back #(
    parameter int MAX_KMER = 12
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_q_valid,
    input  wire cke_pkg::t_op                           i_op,
    output      logic                                   o_pop,
    input  wire logic [3:0]                             i_kmer_length,
    input  wire logic                                   i_canonical,
    output      logic                                   o_out_valid,
    input  wire logic                                   i_out_ready,
    output      logic [cke_pkg::SYM_BITS*MAX_KMER-1:0]  o_kmer_code,
    output      logic                                   o_used_reverse,
    output      logic [cke_pkg::COUNT_W-1:0]            o_hit_count
);
    import cke_pkg::*;

    localparam int W   = SYM_BITS * MAX_KMER;
    localparam int FW  = $clog2(MAX_KMER + 1);
    localparam int SHW = $clog2(W + 1);

    logic [W-1:0]       r_fw, n_fw;
    logic [W-1:0]       r_rv, n_rv;
    logic [FW-1:0]      r_fill, n_fill;
    logic [COUNT_W-1:0] r_total, n_total;

    logic               r_out_valid;
    logic [W-1:0]       r_out_code;
    logic               r_out_rev;
    logic [COUNT_W-1:0] r_out_cnt;

    logic [FW-1:0]      k;
    logic               emit;
    logic [W-1:0]       e_code;
    logic               e_rev;
    logic               out_free;

    function automatic logic [W-1:0] sym_mask(input logic [FW-1:0] n);
        return ~({W{1'b1}} << (SHW'(n) * SHW'(SYM_BITS)));
    endfunction

    // kmer_length zero acts as one, above MAX_KMER acts as MAX_KMER
    always_comb begin
        if (i_kmer_length == 4'd0) begin
            k = FW'(1);
        end else if (32'(i_kmer_length) > MAX_KMER) begin
            k = FW'(MAX_KMER);
        end else begin
            k = FW'(i_kmer_length);
        end
    end

    always_comb begin
        logic [FW-1:0] drop;
        drop    = '0;
        n_fw    = r_fw;
        n_rv    = r_rv;
        n_fill  = r_fill;
        n_total = r_total;
        emit    = 1'b0;
        e_code  = '0;
        e_rev   = 1'b0;
        if (i_op.restart) begin
            n_fw    = '0;
            n_rv    = '0;
            n_fill  = '0;
            n_total = '0;
        end
        if (i_op.clear) begin
            n_fw   = '0;
            n_rv   = '0;
            n_fill = '0;
        end
        if (i_op.append) begin
            // window left fuller than k after kmer_length was lowered
            if (n_fill >= k) begin
                drop   = n_fill - (k - FW'(1));
                n_rv   = n_rv >> (SHW'(drop) * SHW'(SYM_BITS));
                n_fw   = n_fw & sym_mask(k - FW'(1));
                n_fill = k - FW'(1);
            end
            n_fw   = ((n_fw << SYM_BITS) | W'(i_op.code)) & sym_mask(k);
            n_rv   = n_rv | (W'(sym_complement(i_op.code))
                             << (SHW'(n_fill) * SHW'(SYM_BITS)));
            n_fill = n_fill + FW'(1);
            if (n_fill == k) begin
                emit   = 1'b1;
                e_rev  = i_canonical && (n_fw > n_rv);
                e_code = e_rev ? n_rv : n_fw;
                if (n_total != {COUNT_W{1'b1}}) begin
                    n_total = n_total + COUNT_W'(1);
                end
                n_fw   = n_fw & sym_mask(k - FW'(1));
                n_rv   = n_rv >> SYM_BITS;
                n_fill = n_fill - FW'(1);
            end
        end
    end

    assign out_free = !r_out_valid || i_out_ready;
    assign o_pop    = i_q_valid && (!emit || out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw    <= '0;
            r_rv    <= '0;
            r_fill  <= '0;
            r_total <= '0;
        end else if (o_pop) begin
            r_fw    <= n_fw;
            r_rv    <= n_rv;
            r_fill  <= n_fill;
            r_total <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_out_code <= e_code;
            r_out_rev  <= e_rev;
            r_out_cnt  <= n_total;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kmer_code    = r_out_code;
    assign o_used_reverse = r_out_rev;
    assign o_hit_count    = r_out_cnt;

    a_fill_below_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) < MAX_KMER)
        else $error("window fill reached MAX_KMER between beats");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid)
        else $error("pending result dropped");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_cnt != '0))
        else $error("result carries zero hit count");

    a_rev_needs_canon: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && emit && e_rev) |-> i_canonical)
        else $error("reverse complement picked outside canonical mode");

endmodule

`default_nettype wire

// ===== rtl/canonical_kmer_extractor_unit.sv =====
`default_nettype none

// Channel   Handshake                 Payload
// -------   -----------------------   ------------------------------------------
// in        i_in_valid / o_in_ready   i_text_byte, i_restart
// out       o_out_valid / i_out_ready o_kmer_code, o_used_reverse, o_hit_count
// cfg       i_cfg_we                  i_cfg_index, i_cfg_data
//
// One byte per cycle while the queue has room; each byte is classified into a
// two-entry queue, then the window update writes its k-mer beat to the output register.
// The window update and 60-bit canonical compare in the back stage set the clock.
// Reset is synchronous, active low; no clearing pass, the block is ready next cycle.
// A stalled output only holds the back stage; the front keeps taking bytes until
// the queue fills, and header bytes other than '>' or stray newlines enter it only on restart.
module canonical_kmer_extractor_unit #(
    parameter int MAX_KMER = 12
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_in_valid,
    output      logic                                   o_in_ready,
    input  wire logic [7:0]                             i_text_byte,
    input  wire logic                                   i_restart,
    output      logic                                   o_out_valid,
    input  wire logic                                   i_out_ready,
    output      logic [cke_pkg::SYM_BITS*MAX_KMER-1:0]  o_kmer_code,
    output      logic                                   o_used_reverse,
    output      logic [cke_pkg::COUNT_W-1:0]            o_hit_count,
    input  wire logic                                   i_cfg_we,
    input  wire logic [cke_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  wire logic [cke_pkg::CFG_DATA_W-1:0]         i_cfg_data
);
    import cke_pkg::*;

    logic [3:0]            r_kmer_length;
    logic [CFG_DATA_W-1:0] r_alpha_mask;
    logic                  r_fold_lower;
    logic                  r_pur_pyr;
    logic                  r_canonical;

    logic q_ready;
    logic q_valid;
    logic push;
    logic pop;
    t_op  push_op;
    t_op  head_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer_length <= RST_KMER_LENGTH;
            r_alpha_mask  <= RST_ALPHA_MASK;
            r_fold_lower  <= 1'b0;
            r_pur_pyr     <= 1'b0;
            r_canonical   <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_KMER_LENGTH: r_kmer_length <= i_cfg_data[3:0];
                CFG_ALPHA_MASK:  r_alpha_mask  <= i_cfg_data;
                CFG_FOLD_LOWER:  r_fold_lower  <= i_cfg_data[0];
                CFG_PUR_PYR:     r_pur_pyr     <= i_cfg_data[0];
                CFG_CANONICAL:   r_canonical   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_in_ready = q_ready;

    cke_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_q_ready    (q_ready),
        .i_text_byte  (i_text_byte),
        .i_restart    (i_restart),
        .i_alpha_mask (r_alpha_mask),
        .i_fold_lower (r_fold_lower),
        .i_pur_pyr    (r_pur_pyr),
        .o_push       (push),
        .o_op         (push_op)
    );

    cke_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .i_pop   (pop),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_op    (head_op)
    );

    cke_back #(
        .MAX_KMER (MAX_KMER)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_op           (head_op),
        .o_pop          (pop),
        .i_kmer_length  (r_kmer_length),
        .i_canonical    (r_canonical),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kmer_code    (o_kmer_code),
        .o_used_reverse (o_used_reverse),
        .o_hit_count    (o_hit_count)
    );

endmodule

`default_nettype wire
